>>> rtl/trf_pkg.sv
// Shared types and constants for the ring frame receive filter.
// Used by every module of the block; depends on nothing.
package trf_pkg;

   // Route codes carried on the result channel
   localparam logic [2:0] ROUTE_TOKEN     = 3'd0;
   localparam logic [2:0] ROUTE_OWN_BACK  = 3'd1;
   localparam logic [2:0] ROUTE_DELIVER   = 3'd2;
   localparam logic [2:0] ROUTE_BAD_SUM   = 3'd3;
   localparam logic [2:0] ROUTE_PASS_ON   = 3'd4;
   localparam logic [2:0] ROUTE_MALFORMED = 3'd5;

   // Configuration register indexes
   localparam logic [1:0] CSR_STATION_ADDRESS = 2'd0;
   localparam logic [1:0] CSR_TOKEN_MARKER    = 2'd1;

   // Reset values of the configuration registers
   localparam logic [4:0] STATION_ADDRESS_RESET = 5'd1;
   localparam logic [7:0] TOKEN_MARKER_RESET    = 8'hFF;

   // Frame layout: control/source, destination and length precede the data
   localparam int unsigned POS_W      = 9;
   localparam int unsigned SUM_W      = 6;
   localparam logic [POS_W-1:0] HEADER_LEN = 9'd3;
   localparam logic [SUM_W-1:0] SUM_MASK   = 6'h3F;

   // What the frame tracker shows about the byte now being processed
   typedef struct packed {
      logic [7:0]       first_byte;
      logic [7:0]       second_byte;
      logic [SUM_W-1:0] running_sum;
      logic [7:0]       status_byte;
      logic             is_status;
   } frame_view_type;

endpackage

>>> rtl/trf_frame_tracker.sv
// Per-frame state of the receive filter: byte position, header capture and checksum.
// Depends on trf_pkg.
module trf_frame_tracker
   import trf_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           advance,
   input  logic [7:0]     frame_byte,
   input  logic           end_of_frame,
   output frame_view_type view
);

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [SUM_W-1:0] sum_ff, sum_in;
   logic [7:0]       first_ff, first_in;
   logic [7:0]       second_ff, second_in;
   logic [7:0]       length_ff, length_in;

   logic [7:0]       first_now;
   logic [7:0]       second_now;
   logic [7:0]       length_now;
   logic [POS_W-1:0] status_pos;
   logic             in_sum_window;
   logic             status_hit;

   // Header fields as they stand once this byte is taken into account
   always_comb begin
      first_now  = (pos_ff == POS_W'(0)) ? frame_byte : first_ff;
      second_now = (pos_ff == POS_W'(1)) ? frame_byte : second_ff;
      length_now = (pos_ff == POS_W'(2)) ? frame_byte : length_ff;
   end

   // Header and data bytes are summed; the byte just after the data is the status
   assign status_pos    = HEADER_LEN + POS_W'(length_now);
   assign in_sum_window = (pos_ff < HEADER_LEN) || (pos_ff < status_pos);
   assign status_hit    = !in_sum_window && (pos_ff == status_pos);

   assign view.first_byte  = first_now;
   assign view.second_byte = second_now;
   assign view.running_sum = sum_ff;
   assign view.status_byte = frame_byte;
   assign view.is_status   = status_hit;

   // Next state: clear at the end of a frame, otherwise step through it
   always_comb begin
      pos_in    = pos_ff;
      sum_in    = sum_ff;
      first_in  = first_ff;
      second_in = second_ff;
      length_in = length_ff;
      if (advance) begin
         if (end_of_frame) begin
            pos_in    = '0;
            sum_in    = '0;
            first_in  = '0;
            second_in = '0;
            length_in = '0;
         end else begin
            first_in  = first_now;
            second_in = second_now;
            length_in = length_now;
            if (pos_ff != {POS_W{1'b1}}) begin
               pos_in = pos_ff + POS_W'(1);
            end
            if (in_sum_window) begin
               sum_in = (sum_ff + frame_byte[SUM_W-1:0]) & SUM_MASK;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         sum_ff    <= '0;
         first_ff  <= '0;
         second_ff <= '0;
         length_ff <= '0;
      end else begin
         pos_ff    <= pos_in;
         sum_ff    <= sum_in;
         first_ff  <= first_in;
         second_ff <= second_in;
         length_ff <= length_in;
      end
   end

endmodule

>>> rtl/trf_route_decide.sv
// Routing decision and status byte rewrite for a completed frame.
// Depends on trf_pkg.
module trf_route_decide
   import trf_pkg::*;
(
   input  frame_view_type view,
   input  logic [4:0]     station_address,
   input  logic [7:0]     token_marker,
   output logic [2:0]     route,
   output logic [7:0]     status_out,
   output logic [4:0]     source_station,
   output logic [4:0]     dest_station
);

   logic sum_good;

   assign source_station = view.first_byte[7:3];
   assign dest_station   = view.second_byte[7:3];
   assign sum_good       = (view.running_sum == view.status_byte[7:2]);

   // Token first, then malformed, then own source, then own destination
   always_comb begin
      route      = ROUTE_PASS_ON;
      status_out = view.status_byte;
      if (view.first_byte == token_marker) begin
         route      = ROUTE_TOKEN;
         status_out = '0;
      end else if (!view.is_status) begin
         route      = ROUTE_MALFORMED;
         status_out = '0;
      end else if (source_station == station_address) begin
         route = ROUTE_OWN_BACK;
      end else if (dest_station == station_address) begin
         if (sum_good) begin
            route      = ROUTE_DELIVER;
            status_out = view.status_byte | 8'h03;
         end else begin
            route      = ROUTE_BAD_SUM;
            status_out = (view.status_byte & 8'hFC) | 8'h02;
         end
      end
   end

endmodule

>>> rtl/token_ring_frame_receive_filter.sv
// Ring frame receive filter, top level: input register, frame tracker, result register.
// A closing byte waits while a stalled result is held, then its decision is registered.
// Throughput: one byte per cycle but for such waits; one tracker pass between the registers.
// The result register lets the next byte enter while a decision waits to be taken.
// Reset is synchronous: valid flags and frame state clear, station address 1, token 0xFF.
// Depends on trf_pkg, trf_frame_tracker and trf_route_decide.
module token_ring_frame_receive_filter
   import trf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   // Received bytes
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_frame_byte,
   input  logic       req_end_of_frame,
   // Routing decisions
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [2:0] rsp_route,
   output logic [7:0] rsp_status_out,
   output logic [4:0] rsp_source_station,
   output logic [4:0] rsp_dest_station,
   // Configuration writes
   input  logic       csr_write_enable,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_wdata
);

   logic [4:0] station_ff, station_in;
   logic [7:0] token_ff, token_in;

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_eof_ff;

   logic       out_valid_ff, out_valid_in;
   logic [2:0] out_route_ff;
   logic [7:0] out_status_ff;
   logic [4:0] out_source_ff;
   logic [4:0] out_dest_ff;

   logic           advance;
   logic           load_result;
   logic           req_accept;
   frame_view_type view;
   logic [2:0]     route;
   logic [7:0]     status_out;
   logic [4:0]     source_station;
   logic [4:0]     dest_station;

   // Configuration register writes
   always_comb begin
      station_in = station_ff;
      token_in   = token_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_STATION_ADDRESS: station_in = csr_wdata[4:0];
            CSR_TOKEN_MARKER:    token_in   = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         station_ff <= STATION_ADDRESS_RESET;
         token_ff   <= TOKEN_MARKER_RESET;
      end else begin
         station_ff <= station_in;
         token_ff   <= token_in;
      end
   end

   // A held byte moves on unless it closes a frame whose result cannot be stored
   assign load_result = in_valid_ff && in_eof_ff && (!out_valid_ff || !rsp_stall);
   assign advance     = in_valid_ff && (!in_eof_ff || !out_valid_ff || !rsp_stall);
   assign req_stall   = in_valid_ff && !advance;
   assign req_accept  = req_valid && !req_stall;

   // Input register
   assign in_valid_in = req_accept || (in_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_byte_ff <= req_frame_byte;
         in_eof_ff  <= req_end_of_frame;
      end
   end

   trf_frame_tracker u_tracker (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .frame_byte   (in_byte_ff),
      .end_of_frame (in_eof_ff),
      .view         (view)
   );

   trf_route_decide u_decide (
      .view            (view),
      .station_address (station_ff),
      .token_marker    (token_ff),
      .route           (route),
      .status_out      (status_out),
      .source_station  (source_station),
      .dest_station    (dest_station)
   );

   // Result register
   assign out_valid_in = load_result || (out_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_result) begin
         out_route_ff  <= route;
         out_status_ff <= status_out;
         out_source_ff <= source_station;
         out_dest_ff   <= dest_station;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_route          = out_route_ff;
   assign rsp_status_out     = out_status_ff;
   assign rsp_source_station = out_source_ff;
   assign rsp_dest_station   = out_dest_ff;

   // A new result only ever follows an end-of-frame byte in the input register
   assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(in_valid_ff && in_eof_ff))
      else $error("result appeared without an end-of-frame transaction");

   // Tokens and malformed frames carry a zero status byte
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && (out_route_ff == ROUTE_TOKEN || out_route_ff == ROUTE_MALFORMED)
      |-> out_status_ff == 8'h00)
      else $error("status byte not cleared for token or malformed frame");

   // Frames for this station carry the read mark, and the ack mark only with a good sum
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && (out_route_ff == ROUTE_DELIVER || out_route_ff == ROUTE_BAD_SUM)
      |-> out_status_ff[1] && (out_status_ff[0] == (out_route_ff == ROUTE_DELIVER)))
      else $error("read or ack mark wrong for a frame addressed to this station");

   // A byte held in the input register is taken in the cycle its result slot is free
   assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !out_valid_ff |-> advance)
      else $error("input register stalled with an empty result register");

endmodule
